[design/sorted_key_value_table_macros.svh]
// Assertion macros shared by the checker of the sorted key/value table.
`ifndef SORTED_KEY_VALUE_TABLE_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SKVT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sorted_key_value_table check failed");

// Next-cycle implication, disabled during reset.
`define SKVT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sorted_key_value_table check failed");

`endif

[design/skvt_pkg.sv]
// Types and constants of the sorted key/value table.
package skvt_pkg;

  localparam logic [31:0] RESERVED_KEY = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_LOOKUP   = 3'd0,
    ACT_INSERT   = 3'd1,
    ACT_UPDATE   = 3'd2,
    ACT_ERASE    = 3'd3,
    ACT_ERASE_V  = 3'd4,
    ACT_UNUSED   = 3'd5,
    ACT_CLEAR    = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUP       = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_SRCH_CMP, S_PROBE, S_SHUP, S_SHUP_W,
    S_SHDN, S_SHDN_W, S_SCAN, S_SCAN_CHK, S_FINISH
  } state_e;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_SRCH_RD, DP_SRCH_CMP, DP_PROBE_RD,
    DP_SET_NF, DP_SET_DUP, DP_SET_FULL, DP_TAKE_HIT, DP_UPD_WR,
    DP_SHUP_INIT, DP_SHUP_RD, DP_SHUP_WR, DP_INS_WR,
    DP_SHDN_RD, DP_SHDN_WR, DP_DEC,
    DP_SCAN_RD, DP_SCAN_NEXT, DP_TAKE_MATCH, DP_UNUSED_KEY,
    DP_CLEAR, DP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic srch_done;
    logic hit;
    logic full;
    logic reserved;
    logic shup_done;
    logic shdn_done;
    logic scan_end;
    logic vmatch;
    logic kmis;
    logic out_free;
  } dp_sts_t;

endpackage

[design/skvt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module skvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[design/skvt_ctrl.sv]
// Controller state machine that sequences search, shift and scan steps.
module skvt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [2:0]        action_i,
  input  skvt_pkg::dp_sts_t sts_i,
  output logic              in_stall_o,
  output skvt_pkg::dp_cmd_t cmd_o
);
  import skvt_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] act_q, act_d;

  // State and captured action
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_LOOKUP;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end

  assign act_d = (state_q == S_IDLE && in_valid_i) ? action_i : act_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (action_i)
            ACT_LOOKUP, ACT_INSERT, ACT_UPDATE, ACT_ERASE: state_d = S_SRCH;
            ACT_ERASE_V, ACT_UNUSED:                       state_d = S_SCAN;
            default:                                       state_d = S_FINISH;
          endcase
        end
      end
      S_SRCH:     state_d = sts_i.srch_done ? S_PROBE : S_SRCH_CMP;
      S_SRCH_CMP: state_d = S_SRCH;
      S_PROBE: begin
        state_d = S_FINISH;
        case (act_q)
          ACT_INSERT: begin
            if (!sts_i.reserved && !sts_i.hit && !sts_i.full) state_d = S_SHUP;
          end
          ACT_ERASE: begin
            if (sts_i.hit) state_d = S_SHDN;
          end
          default: state_d = S_FINISH;
        endcase
      end
      S_SHUP:   state_d = sts_i.shup_done ? S_FINISH : S_SHUP_W;
      S_SHUP_W: state_d = S_SHUP;
      S_SHDN:   state_d = sts_i.shdn_done ? S_FINISH : S_SHDN_W;
      S_SHDN_W: state_d = S_SHDN;
      S_SCAN:   state_d = sts_i.scan_end ? S_FINISH : S_SCAN_CHK;
      S_SCAN_CHK: begin
        state_d = S_SCAN;
        if (act_q == ACT_ERASE_V && sts_i.vmatch) state_d = S_SHDN;
        if (act_q == ACT_UNUSED && sts_i.kmis)    state_d = S_FINISH;
      end
      S_FINISH: if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o.op = DP_NOP;
    case (state_q)
      S_IDLE:     if (in_valid_i) cmd_o.op = DP_LOAD;
      S_SRCH:     cmd_o.op = sts_i.srch_done ? DP_PROBE_RD : DP_SRCH_RD;
      S_SRCH_CMP: cmd_o.op = DP_SRCH_CMP;
      S_PROBE: begin
        case (act_q)
          ACT_LOOKUP: cmd_o.op = sts_i.hit ? DP_TAKE_HIT : DP_SET_NF;
          ACT_INSERT: begin
            if (sts_i.reserved || sts_i.hit) cmd_o.op = DP_SET_DUP;
            else if (sts_i.full)             cmd_o.op = DP_SET_FULL;
            else                             cmd_o.op = DP_SHUP_INIT;
          end
          ACT_UPDATE: cmd_o.op = sts_i.hit ? DP_UPD_WR : DP_SET_NF;
          ACT_ERASE:  cmd_o.op = sts_i.hit ? DP_TAKE_HIT : DP_SET_NF;
          default:    cmd_o.op = DP_NOP;
        endcase
      end
      S_SHUP:   cmd_o.op = sts_i.shup_done ? DP_INS_WR : DP_SHUP_RD;
      S_SHUP_W: cmd_o.op = DP_SHUP_WR;
      S_SHDN:   cmd_o.op = sts_i.shdn_done ? DP_DEC : DP_SHDN_RD;
      S_SHDN_W: cmd_o.op = DP_SHDN_WR;
      S_SCAN: begin
        if (!sts_i.scan_end)         cmd_o.op = DP_SCAN_RD;
        else if (act_q == ACT_UNUSED) cmd_o.op = DP_UNUSED_KEY;
        else                          cmd_o.op = DP_SET_NF;
      end
      S_SCAN_CHK: begin
        cmd_o.op = DP_SCAN_NEXT;
        if (act_q == ACT_ERASE_V && sts_i.vmatch) cmd_o.op = DP_TAKE_MATCH;
        if (act_q == ACT_UNUSED && sts_i.kmis)    cmd_o.op = DP_UNUSED_KEY;
      end
      S_FINISH: if (sts_i.out_free) cmd_o.op = (act_q == ACT_CLEAR) ? DP_CLEAR : DP_FINISH;
      default:  cmd_o.op = DP_NOP;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
endmodule

[design/skvt_dp.sv]
// Datapath: key/value memories, search and shift registers, result register.
module skvt_dp #(
  parameter int CAPACITY = 64,
  parameter int VW       = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  skvt_pkg::dp_cmd_t               cmd_i,
  output skvt_pkg::dp_sts_t               sts_o,
  input  logic [2:0]                      action_i,
  input  logic [31:0]                     key_i,
  input  logic [31:0]                     value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [31:0]                     value_out_o,
  output logic [31:0]                     key_out_o,
  output logic [$clog2(CAPACITY+1)-1:0]   entries_in_use_o
);
  import skvt_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0]   key_q;
  logic [VW-1:0] val_q;
  logic [2:0]    act_q;
  logic [CW-1:0] base_q, len_q, idx_q, cnt_q;
  logic [1:0]    st_q;
  logic [VW-1:0] vout_q;
  logic [31:0]   kout_q;
  logic          out_valid_q;
  logic [1:0]    ostat_q;
  logic [31:0]   ovalue_q, okey_q;
  logic [CW-1:0] ocnt_q;

  logic [CW-1:0] half, mid;
  logic [CW-1:0] idx_dec, idx_inc;
  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wkey, rkey;
  logic [VW-1:0] wval, rval;
  logic          out_free;

  assign half    = len_q >> 1;
  assign mid     = CW'(base_q + half);
  assign idx_dec = CW'(idx_q - 1'b1);
  assign idx_inc = CW'(idx_q + 1'b1);

  // Memory address and data selection
  always_comb begin
    re    = 1'b0;
    we    = 1'b0;
    raddr = idx_q[AW-1:0];
    waddr = idx_q[AW-1:0];
    wkey  = rkey;
    wval  = rval;
    case (cmd_i.op)
      DP_SRCH_RD:  begin re = 1'b1; raddr = mid[AW-1:0];                       end
      DP_PROBE_RD: begin re = 1'b1; raddr = base_q[AW-1:0];                    end
      DP_SHUP_RD:  begin re = 1'b1; raddr = idx_dec[AW-1:0];                   end
      DP_SHDN_RD:  begin re = 1'b1; raddr = idx_inc[AW-1:0];                   end
      DP_SCAN_RD:  begin re = 1'b1;                                            end
      DP_SHUP_WR, DP_SHDN_WR: we = 1'b1;
      DP_INS_WR, DP_UPD_WR: begin
        we    = 1'b1;
        waddr = base_q[AW-1:0];
        wkey  = key_q;
        wval  = val_q;
      end
      default: re = 1'b0;
    endcase
  end

  skvt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wkey),
    .re_i(re), .raddr_i(raddr), .rdata_o(rkey)
  );

  skvt_ram #(.WIDTH(VW), .DEPTH(CAPACITY)) u_val_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wval),
    .re_i(re), .raddr_i(raddr), .rdata_o(rval)
  );

  // Working registers of the current transaction
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      DP_LOAD: begin
        key_q  <= key_i;
        val_q  <= value_i[VW-1:0];
        act_q  <= action_i;
        base_q <= '0;
        len_q  <= cnt_q;
        idx_q  <= '0;
        st_q   <= ST_OK;
        vout_q <= '0;
        kout_q <= '0;
      end
      DP_SRCH_CMP: begin
        if (rkey < key_q) begin
          base_q <= CW'(mid + 1'b1);
          len_q  <= CW'(len_q - half - 1'b1);
        end else begin
          len_q  <= half;
        end
      end
      DP_SET_NF:     st_q <= ST_NOT_FOUND;
      DP_SET_DUP:    st_q <= ST_DUP;
      DP_SET_FULL:   st_q <= ST_FULL;
      DP_TAKE_HIT: begin
        vout_q <= (act_q == ACT_LOOKUP || act_q == ACT_ERASE) ? rval : '0;
        idx_q  <= base_q;
      end
      DP_SHUP_INIT:  idx_q <= cnt_q;
      DP_SHUP_WR:    idx_q <= idx_dec;
      DP_SHDN_WR:    idx_q <= idx_inc;
      DP_SCAN_NEXT:  idx_q <= idx_inc;
      DP_TAKE_MATCH: begin
        vout_q <= rval;
        kout_q <= rkey;
      end
      DP_UNUSED_KEY: kout_q <= 32'(idx_q);
      default:       st_q <= st_q;
    endcase
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      case (cmd_i.op)
        DP_INS_WR: cnt_q <= CW'(cnt_q + 1'b1);
        DP_DEC:    cnt_q <= CW'(cnt_q - 1'b1);
        DP_CLEAR:  cnt_q <= '0;
        default:   cnt_q <= cnt_q;
      endcase
    end
  end

  // Result register, free once the waiting transaction is taken
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == DP_FINISH || cmd_i.op == DP_CLEAR) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_FINISH || cmd_i.op == DP_CLEAR) begin
      ostat_q  <= st_q;
      ovalue_q <= 32'(vout_q);
      okey_q   <= kout_q;
      ocnt_q   <= (cmd_i.op == DP_CLEAR) ? '0 : cnt_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = ostat_q;
  assign value_out_o      = ovalue_q;
  assign key_out_o        = okey_q;
  assign entries_in_use_o = ocnt_q;

  // Status toward the controller
  assign sts_o.srch_done = (len_q == '0);
  assign sts_o.hit       = (base_q < cnt_q) && (rkey == key_q);
  assign sts_o.full      = (cnt_q == CW'(CAPACITY));
  assign sts_o.reserved  = (key_q == RESERVED_KEY);
  assign sts_o.shup_done = (idx_q == base_q);
  assign sts_o.shdn_done = (idx_inc >= cnt_q);
  assign sts_o.scan_end  = (idx_q >= cnt_q);
  assign sts_o.vmatch    = (rval == val_q);
  assign sts_o.kmis      = (rkey != 32'(idx_q));
  assign sts_o.out_free  = out_free;
endmodule

[design/sorted_key_value_table.sv]
// Sorted key/value table: top level joining controller and datapath.
//
// Input channel: action_i, key_i, value_i with in_valid_i / in_stall_o.
// Output channel: status_o, value_out_o, key_out_o, entries_in_use_o with
// out_valid_o / out_stall_i. Each input transaction gives one output.
// One transaction is worked on at a time; in_stall_o is low only while the
// controller is idle, and the next transaction may enter while a result is
// still held in the output register.
// Steps per transaction:
//   binary search: each halving step reads the middle entry, then compares;
//   a probe read follows. Insert shifts entries up, each a read then a write;
//   erase shifts them down alike. Value match and unused-key scans read each
//   entry, then check it. All of these steps share the single read port of
//   the key and value memories.
// When the receiver stalls, the result holds and the controller waits in
// its final state until the output register frees up.
// Reset clears the entry count and the control state; the memories are not
// cleared since no entry at or above the count is taken as a result.
module sorted_key_value_table #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    action_i,
  input  logic [31:0]                   key_i,
  input  logic [31:0]                   value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [31:0]                   value_out_o,
  output logic [31:0]                   key_out_o,
  output logic [$clog2(CAPACITY+1)-1:0] entries_in_use_o
);
  import skvt_pkg::*;

  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  dp_cmd_t cmd;
  dp_sts_t sts;

  skvt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .action_i,
    .sts_i(sts), .in_stall_o, .cmd_o(cmd)
  );

  skvt_dp #(.CAPACITY(CAPACITY), .VW(VW)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .action_i, .key_i, .value_i,
    .out_valid_o, .out_stall_i, .status_o, .value_out_o, .key_out_o,
    .entries_in_use_o
  );
endmodule

[design/skvt_checker.sv]
// Port-level checker for the sorted key/value table, bound to the top level.
`include "sorted_key_value_table_macros.svh"

module skvt_checker #(
  parameter int CAPACITY = 64
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [2:0]                    action_i,
  input logic [31:0]                   key_i,
  input logic [31:0]                   value_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [1:0]                    status_o,
  input logic [31:0]                   value_out_o,
  input logic [31:0]                   key_out_o,
  input logic [$clog2(CAPACITY+1)-1:0] entries_in_use_o
);
  import skvt_pkg::*;

  // A held result stays valid, and its value and entry count do not change while stalled
  `SKVT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(value_out_o) && $stable(entries_in_use_o))

  // Entry count never passes the capacity
  `SKVT_ASSERT_NOW(a_cnt_max, out_valid_o, entries_in_use_o <= ($clog2(CAPACITY+1))'(CAPACITY))

  // A failed transaction reports no value
  `SKVT_ASSERT_NOW(a_fail_zero, out_valid_o && status_o != ST_OK, value_out_o == '0)

  // A full status only when the table is full
  `SKVT_ASSERT_NOW(a_full_cnt, out_valid_o && status_o == ST_FULL, entries_in_use_o == ($clog2(CAPACITY+1))'(CAPACITY))

  // Work on one transaction at a time
  `SKVT_ASSERT_NEXT(a_busy, in_valid_i && !in_stall_o, in_stall_o)
endmodule

bind sorted_key_value_table skvt_checker #(.CAPACITY(CAPACITY)) u_skvt_checker (.*);
